@@ rtl/core/hse_pkg.sv @@
`timescale 1ns / 1ps

package hse_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned COUNT_W = 11;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned M_TDATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic REG_HASH_SEED = 1'b0;
  localparam logic [KEY_W-1:0] HASH_SEED_RESET = 64'd5381;

endpackage

@@ rtl/core/hse_hash.sv @@
`timescale 1ns / 1ps

module hse_hash #(
  parameter int unsigned NUM_BUCKETS = 256,
  parameter int unsigned KEY_BYTES = 8,
  localparam int unsigned BucketW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
  localparam int unsigned KeyW = KEY_BYTES * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hse_pkg::KEY_W-1:0]    seed_i,
  input  logic [KeyW-1:0]              key_i,
  input  logic [hse_pkg::LEN_W-1:0]    len_i,
  output logic                         done_o,
  output logic [BucketW-1:0]           bucket_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HASH = 2'd1;
  localparam logic [1:0] PH_MOD  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam bit IsPow2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
  localparam int unsigned ModSteps = hse_pkg::KEY_W / 2;
  localparam int unsigned StepW = $clog2(ModSteps);
  localparam logic [StepW-1:0] LastStep = StepW'(ModSteps - 1);
  localparam logic [BucketW+1:0] Div1 = (BucketW + 2)'(NUM_BUCKETS);
  localparam logic [BucketW+1:0] Div2 = (BucketW + 2)'(2 * NUM_BUCKETS);
  localparam logic [BucketW+1:0] Div3 = (BucketW + 2)'(3 * NUM_BUCKETS);

  logic [1:0]                   phase_q, phase_d;
  logic [hse_pkg::KEY_W-1:0]    acc_q, acc_d;
  logic [KeyW-1:0]              kshift_q, kshift_d;
  logic [hse_pkg::LEN_W-1:0]    left_q, left_d;
  logic [StepW-1:0]             mstep_q, mstep_d;
  logic [BucketW-1:0]           rem_q, rem_d;
  logic [BucketW+1:0]           trial;

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    kshift_d = kshift_q;
    left_d   = left_q;
    mstep_d  = mstep_q;
    rem_d    = rem_q;
    trial    = {rem_q, acc_q[hse_pkg::KEY_W-1 -: 2]};
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          acc_d    = seed_i;
          kshift_d = key_i;
          left_d   = len_i;
          phase_d  = PH_HASH;
        end
      end
      PH_HASH: begin
        if (left_q != '0) begin
          acc_d    = acc_q + (acc_q << 5) + hse_pkg::KEY_W'(kshift_q[7:0]);
          kshift_d = kshift_q >> 8;
          left_d   = left_q - 1'b1;
        end else if (IsPow2) begin
          rem_d   = acc_q[BucketW-1:0];
          phase_d = PH_DONE;
        end else begin
          rem_d   = '0;
          mstep_d = '0;
          phase_d = PH_MOD;
        end
      end
      PH_MOD: begin
        if (trial >= Div3) begin
          rem_d = BucketW'(trial - Div3);
        end else if (trial >= Div2) begin
          rem_d = BucketW'(trial - Div2);
        end else if (trial >= Div1) begin
          rem_d = BucketW'(trial - Div1);
        end else begin
          rem_d = BucketW'(trial);
        end
        acc_d   = acc_q << 2;
        mstep_d = mstep_q + 1'b1;
        if (mstep_q == LastStep) begin
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    kshift_q <= kshift_d;
    left_q   <= left_d;
    mstep_q  <= mstep_d;
    rem_q    <= rem_d;
  end

  assign done_o   = (phase_q == PH_DONE);
  assign bucket_o = rem_q;

endmodule

@@ rtl/core/hash_set_engine.sv @@
`timescale 1ns / 1ps

// Set of short byte-string keys held in a bucketed table of WAYS slots per bucket.
// Requests enter on the s_axis channel: tuser carries the command (insert, remove,
// contains or clear) and tdata the key and its byte length. Each request gives
// exactly one response on the m_axis channel with the hit flag, the status code
// and the number of stored keys after the operation.
// The bucket is found with a djb2 hash computed one key byte per cycle, followed,
// when NUM_BUCKETS is not a power of two, by a remainder unit that retires two
// hash bits per cycle. The bucket row is then read, all ways are compared at
// once and the row is written back when the operation changes it.
// A request passes from the hash to the row read, the compare and the output
// register; the next request is accepted only once the response of the last
// one is loaded there. A clear sweeps the table one bucket per cycle, then responds.
// After reset the same sweep runs and s_axis_tready_o stays low meanwhile;
// the APB port is served at all times.
// The response sits in an output register. While the receiver stalls it holds,
// and the next request may still be accepted and worked on up to its response.

module hash_set_engine #(
  parameter int unsigned NUM_BUCKETS = 256,
  parameter int unsigned WAYS = 4,
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request: tdata [63:0] key, [67:64] key_len, [71:68] zero.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [hse_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // Request: tuser [1:0] command.
  input  logic [hse_pkg::CMD_W-1:0]         s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // Response: tdata [0] hit, [1] status, [12:2] entry_count, [15:13] zero.
  output logic [hse_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [3:0]                        paddr_i,
  input  logic [63:0]                       pwdata_i,
  output logic [63:0]                       prdata_o,
  output logic                              pready_o
);

  localparam int unsigned BucketW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned KeyW = KEY_BYTES * 8;
  localparam int unsigned LenW = hse_pkg::LEN_W;
  localparam int unsigned ValidBit = KeyW + LenW;
  localparam int unsigned EntryW = KeyW + LenW + 1;
  localparam int unsigned CountW = $clog2(NUM_BUCKETS * WAYS + 1);
  localparam logic [BucketW-1:0] LastBucket = BucketW'(NUM_BUCKETS - 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(KEY_BYTES);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  typedef logic [WAYS-1:0][EntryW-1:0] row_t;

  row_t                           mem_q [NUM_BUCKETS];
  row_t                           row_q;
  row_t                           mem_wdata;
  logic                           mem_we;
  logic [BucketW-1:0]             mem_waddr;

  logic [2:0]                     state_q, state_d;
  logic [BucketW-1:0]             sweep_q, sweep_d;
  logic                           clear_req_q, clear_req_d;
  logic [CountW-1:0]              count_q, count_d;
  logic [hse_pkg::KEY_W-1:0]      seed_q;
  logic                           m_tvalid_q, m_tvalid_d;

  logic [hse_pkg::CMD_W-1:0]      cmd_q, cmd_d;
  logic [KeyW-1:0]                key_q, key_d;
  logic [LenW-1:0]                len_q, len_d;
  logic [BucketW-1:0]             bucket_q, bucket_d;
  logic                           res_hit_q, res_hit_d;
  logic                           res_status_q, res_status_d;
  logic                           out_hit_q, out_hit_d;
  logic                           out_status_q, out_status_d;
  logic [hse_pkg::COUNT_W-1:0]    out_count_q, out_count_d;

  logic                           s_accept;
  logic                           load_out;
  logic                           cfg_write;
  logic [hse_pkg::CMD_W-1:0]      cmd_in;
  logic [LenW-1:0]                len_raw;
  logic [LenW-1:0]                len_sat;
  logic [hse_pkg::KEY_W-1:0]      key_raw;
  logic [hse_pkg::KEY_W-1:0]      key_masked;
  logic                           hash_start;
  logic                           hash_done;
  logic [BucketW-1:0]             hash_bucket;

  logic                           match_found;
  logic [WayW-1:0]                match_way;
  logic                           free_found;
  logic [WayW-1:0]                free_way;

  assign cmd_in   = s_axis_tuser_i;
  assign key_raw  = s_axis_tdata_i[hse_pkg::KEY_W-1:0];
  assign len_raw  = s_axis_tdata_i[hse_pkg::KEY_W +: LenW];
  assign len_sat  = (len_raw > MaxLen) ? MaxLen : len_raw;

  always_comb begin
    for (int b = 0; b < hse_pkg::KEY_W / 8; b++) begin
      key_masked[b*8 +: 8] = (LenW'(b) < len_sat) ? key_raw[b*8 +: 8] : 8'h00;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign hash_start      = s_accept && (cmd_in != hse_pkg::CMD_CLEAR);
  assign load_out        = (state_q == ST_OUT) && (!m_tvalid_q || m_axis_tready_i);

  hse_hash #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .KEY_BYTES  (KEY_BYTES)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .seed_i  (seed_q),
    .key_i   (key_masked[KeyW-1:0]),
    .len_i   (len_sat),
    .done_o  (hash_done),
    .bucket_o(hash_bucket)
  );

  always_comb begin
    match_found = 1'b0;
    match_way   = '0;
    free_found  = 1'b0;
    free_way    = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row_q[w][ValidBit]) begin
        if (!match_found && (row_q[w][ValidBit-1:KeyW] == len_q) &&
            (row_q[w][KeyW-1:0] == key_q)) begin
          match_found = 1'b1;
          match_way   = WayW'(w);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_way   = WayW'(w);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    clear_req_d  = clear_req_q;
    count_d      = count_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    len_d        = len_q;
    bucket_d     = bucket_q;
    res_hit_d    = res_hit_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = bucket_q;
    mem_wdata    = row_q;
    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == LastBucket) begin
          clear_req_d = 1'b0;
          state_d     = clear_req_q ? ST_OUT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_accept) begin
          cmd_d = cmd_in;
          key_d = key_masked[KeyW-1:0];
          len_d = len_sat;
          if (cmd_in == hse_pkg::CMD_CLEAR) begin
            sweep_d      = '0;
            clear_req_d  = 1'b1;
            count_d      = '0;
            res_hit_d    = 1'b0;
            res_status_d = hse_pkg::STATUS_OK;
            state_d      = ST_INIT;
          end else begin
            state_d = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          bucket_d = hash_bucket;
          state_d  = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        res_hit_d    = match_found;
        res_status_d = hse_pkg::STATUS_OK;
        unique case (cmd_q)
          hse_pkg::CMD_INSERT: begin
            if (!match_found) begin
              if (!free_found) begin
                res_status_d = hse_pkg::STATUS_FULL;
              end else begin
                mem_we              = 1'b1;
                mem_wdata[free_way] = {1'b1, len_q, key_q};
                count_d             = count_q + CountW'(1);
              end
            end
          end
          hse_pkg::CMD_REMOVE: begin
            if (match_found) begin
              mem_we                         = 1'b1;
              mem_wdata[match_way][ValidBit] = 1'b0;
              if (count_q != '0) begin
                count_d = count_q - CountW'(1);
              end
            end
          end
          default: begin
          end
        endcase
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_hit_d    = out_hit_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    m_tvalid_d   = m_tvalid_q;
    if (load_out) begin
      out_hit_d    = res_hit_q;
      out_status_d = res_status_q;
      out_count_d  = hse_pkg::COUNT_W'(count_q);
      m_tvalid_d   = 1'b1;
    end else if (m_axis_tready_i) begin
      m_tvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    row_q <= mem_q[bucket_q];
  end

  assign cfg_write = psel_i && penable_i && pwrite_i && pready_o &&
                     (paddr_i[3] == hse_pkg::REG_HASH_SEED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      clear_req_q <= 1'b0;
      count_q     <= '0;
      m_tvalid_q  <= 1'b0;
      seed_q      <= hse_pkg::HASH_SEED_RESET;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      clear_req_q <= clear_req_d;
      count_q     <= count_d;
      m_tvalid_q  <= m_tvalid_d;
      if (cfg_write) begin
        seed_q <= pwdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    len_q        <= len_d;
    bucket_q     <= bucket_d;
    res_hit_q    <= res_hit_d;
    res_status_q <= res_status_d;
    out_hit_q    <= out_hit_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign pready_o        = 1'b1;
  assign prdata_o        = (paddr_i[3] == hse_pkg::REG_HASH_SEED) ? seed_q : '0;
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = {3'b000, out_count_q, out_status_q, out_hit_q};

endmodule

@@ rtl/core/hse_checker.sv @@
`timescale 1ns / 1ps

module hse_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [hse_pkg::M_TDATA_W-1:0]   m_axis_tdata_o
);

  logic [1:0] pend_q, pend_d;
  logic       s_accept;
  logic       m_accept;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign m_accept = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    pend_d = pend_q;
    if (s_accept && !m_accept) begin
      pend_d = pend_q + 2'd1;
    end else if (!s_accept && m_accept) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // A request keeps the block busy, so requests are never accepted back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready_o)
    else $error("request accepted back to back");

  // Every response belongs to a request not yet answered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (pend_q != 2'd0))
    else $error("response without a pending request");

  // A refused insert never reports the key as present.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[1] == hse_pkg::STATUS_FULL)) |-> !m_axis_tdata_o[0])
    else $error("full status together with hit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled response changed");

endmodule

bind hash_set_engine hse_checker u_hse_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import hse_pkg::*;

  localparam int unsigned NBUCKETS      = 256;
  localparam int unsigned NWAYS         = 4;
  localparam int unsigned MAX_KEY_BYTES = 8;
  localparam int unsigned NSLOTS        = NBUCKETS * NWAYS;
  localparam int unsigned POOL_SIZE     = 30;
  localparam int unsigned POOL_BUCKETS  = 5;
  localparam int unsigned PHASE_ITEMS   = 140;
  localparam logic [3:0]  SEED_ADDR     = 4'(REG_HASH_SEED) * 4'd8;

  typedef struct packed {
    logic               hit;
    logic               status;
    logic [COUNT_W-1:0] count;
  } set_reply_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC,
    READY_SPARSE
  } ready_pattern_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [S_TDATA_W-1:0]  s_axis_tdata_i;
  logic [CMD_W-1:0]      s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;
  logic                  psel_i;
  logic                  penable_i;
  logic                  pwrite_i;
  logic [3:0]            paddr_i;
  logic [63:0]           pwdata_i;
  logic [63:0]           prdata_o;
  logic                  pready_o;

  logic [63:0]           hash_seed_shadow = HASH_SEED_RESET;
  logic [63:0]           shadow_key   [NSLOTS];
  logic [3:0]            shadow_len   [NSLOTS];
  logic                  shadow_valid [NSLOTS];
  logic [COUNT_W-1:0]    shadow_count = '0;
  set_reply_t            set_replies_q [$];
  int unsigned           error_count = 0;

  logic [63:0]           pool_key [POOL_SIZE];
  int unsigned           pool_len [POOL_SIZE];

  int unsigned           burst_left = 0;
  int unsigned           gap_left = 0;
  ready_pattern_t        stall_mode = READY_ALWAYS;
  logic [7:0]            stall_cycle = '0;

  hash_set_engine u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel_i          (psel_i),
    .penable_i       (penable_i),
    .pwrite_i        (pwrite_i),
    .paddr_i         (paddr_i),
    .pwdata_i        (pwdata_i),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [63:0] low_mask(int unsigned n);
    if (n >= MAX_KEY_BYTES) begin
      return '1;
    end
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic logic [63:0] djb2_of(logic [63:0] k, int unsigned n);
    logic [63:0] h;
    h = hash_seed_shadow;
    for (int i = 0; i < n; i++) begin
      h = h * 64'd33 + 64'(k[8*i +: 8]);
    end
    return h;
  endfunction

  function automatic int unsigned bucket_of(logic [63:0] k, int unsigned n);
    return int'(djb2_of(k, n) % NBUCKETS);
  endfunction

  // Rewrites the last key byte so that the key lands in the target bucket.
  function automatic logic [63:0] place_in_bucket(logic [63:0] k, int unsigned n,
                                                  int unsigned target);
    logic [63:0] t;
    if (n == 0) begin
      return '0;
    end
    t = djb2_of(k, n - 1) * 64'd33;
    k[8*(n-1) +: 8] = 8'(target) - t[7:0];
    return k & low_mask(n);
  endfunction

  function automatic set_reply_t apply_set_command(logic [CMD_W-1:0] cmd, logic [63:0] key,
                                                   logic [3:0] len_field);
    int unsigned n;
    int unsigned base;
    logic [63:0] k;
    int          match_way;
    int          free_way;
    set_reply_t  r;
    n = (len_field > MAX_KEY_BYTES) ? MAX_KEY_BYTES : len_field;
    k = key & low_mask(n);
    r = '0;
    match_way = -1;
    free_way = -1;
    if (cmd == CMD_CLEAR) begin
      foreach (shadow_valid[s]) shadow_valid[s] = 1'b0;
      shadow_count = '0;
    end else begin
      base = bucket_of(k, n) * NWAYS;
      for (int w = 0; w < NWAYS; w++) begin
        if (shadow_valid[base+w]) begin
          if (match_way < 0 && shadow_len[base+w] == n && shadow_key[base+w] == k) begin
            match_way = w;
          end
        end else if (free_way < 0) begin
          free_way = w;
        end
      end
      r.hit = (match_way >= 0);
      if (cmd == CMD_INSERT && match_way < 0) begin
        if (free_way < 0) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_key[base+free_way] = k;
          shadow_len[base+free_way] = 4'(n);
          shadow_valid[base+free_way] = 1'b1;
          shadow_count++;
        end
      end else if (cmd == CMD_REMOVE && match_way >= 0) begin
        shadow_valid[base+match_way] = 1'b0;
        if (shadow_count > 0) begin
          shadow_count--;
        end
      end
    end
    r.count = shadow_count;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_reply(logic [M_TDATA_W-1:0] data);
    set_reply_t want;
    if (set_replies_q.size() == 0) begin
      report_mismatch($sformatf("response 0x%h with no request pending", data));
    end else begin
      want = set_replies_q.pop_front();
      if (data[0] !== want.hit) begin
        report_mismatch($sformatf("hit %b, predicted %b", data[0], want.hit));
      end
      if (data[1] !== want.status) begin
        report_mismatch($sformatf("status %b, predicted %b", data[1], want.status));
      end
      if (data[2 +: COUNT_W] !== want.count) begin
        report_mismatch($sformatf("entry_count %0d, predicted %0d",
                                  data[2 +: COUNT_W], want.count));
      end
    end
  endtask

  // Response side: check on every transfer, stall on a pattern that changes now and then.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      check_reply(m_axis_tdata_o);
    end
    if (stall_cycle == 0) begin
      stall_mode <= ready_pattern_t'($urandom_range(0, 3));
      stall_cycle <= 8'($urandom_range(20, 120));
    end else begin
      stall_cycle <= stall_cycle - 8'd1;
    end
    case (stall_mode)
      READY_ALWAYS: begin
        m_axis_tready_i <= 1'b1;
      end
      READY_RANDOM: begin
        m_axis_tready_i <= ($urandom_range(0, 9) < 7);
      end
      READY_PERIODIC: begin
        m_axis_tready_i <= (stall_cycle[1:0] == 2'd0);
      end
      default: begin
        m_axis_tready_i <= ($urandom_range(0, 15) == 0);
      end
    endcase
  end

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [63:0] key, logic [3:0] len);
    if (gap_left > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap_left) @(posedge clk_i);
      gap_left = 0;
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {4'b0, len, key};
    s_axis_tuser_i <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    set_replies_q.push_back(apply_set_command(cmd, key, len));
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      gap_left = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
    end
  endtask

  // A clear responds only once its sweep is over; the drain still allows for a full sweep.
  task automatic drain_stream();
    s_axis_tvalid_i <= 1'b0;
    while (set_replies_q.size() != 0) @(posedge clk_i);
    repeat (NBUCKETS + 40) @(posedge clk_i);
  endtask

  task automatic apb_transfer(logic write, logic [3:0] addr, logic [63:0] wdata,
                              output logic [63:0] rdata);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= write;
    paddr_i <= addr;
    pwdata_i <= wdata;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    rdata = prdata_o;
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
  endtask

  task automatic set_hash_seed(logic [63:0] value);
    logic [63:0] readback;
    apb_transfer(1'b1, SEED_ADDR, value, readback);
    hash_seed_shadow = value;
    apb_transfer(1'b0, SEED_ADDR, '0, readback);
    if (readback !== value) begin
      report_mismatch($sformatf("hash_seed reads 0x%h, written 0x%h", readback, value));
    end
  endtask

  task automatic test_register_access();
    logic [63:0] readback;
    apb_transfer(1'b0, SEED_ADDR, '0, readback);
    if (readback !== HASH_SEED_RESET) begin
      report_mismatch($sformatf("hash_seed resets to 0x%h", readback));
    end
    set_hash_seed('1);
    set_hash_seed(HASH_SEED_RESET);
  endtask

  task automatic test_directed_cases();
    logic [63:0] fill [5];
    int unsigned fill_len [5];
    logic [63:0] fresh;
    logic [63:0] stem;
    int unsigned bkt;
    int unsigned stem_bkt;
    send_request(CMD_INSERT, 64'd0, 4'd1);
    send_request(CMD_INSERT, '1, 4'd8);
    send_request(CMD_INSERT, {$urandom, $urandom}, 4'd0);
    send_request(CMD_CONTAINS, {$urandom, $urandom}, 4'd0);
    send_request(CMD_CONTAINS, '1, 4'd15);
    send_request(CMD_INSERT, '1, 4'd12);
    send_request(CMD_CONTAINS, 64'hA5A5_5A5A_C3C3_3C00, 4'd1);
    send_request(CMD_REMOVE, 64'd0, 4'd2);
    send_request(CMD_REMOVE, 64'd0, 4'd1);
    send_request(CMD_CONTAINS, 64'd0, 4'd1);

    // Five keys for one bucket: the fifth is refused.
    bkt = $urandom_range(0, NBUCKETS - 1);
    for (int i = 0; i < 5; i++) begin
      fill_len[i] = (i == 3) ? 1 : $urandom_range(2, 8);
      fill[i] = place_in_bucket({$urandom, $urandom}, fill_len[i], bkt);
      send_request(CMD_INSERT, fill[i], 4'(fill_len[i]));
    end

    // A 3-byte key whose hash is a multiple of 8 shares its bucket with the same
    // bytes taken as a 4-byte key, so only the length tells them apart.
    stem_bkt = 8 * $urandom_range(0, NBUCKETS / 8 - 1);
    if (stem_bkt == bkt) begin
      stem_bkt = (stem_bkt + 8) % NBUCKETS;
    end
    stem = place_in_bucket({$urandom, $urandom}, 3, stem_bkt);
    send_request(CMD_INSERT, stem, 4'd3);
    send_request(CMD_CONTAINS, stem, 4'd4);
    send_request(CMD_INSERT, stem, 4'd4);
    send_request(CMD_REMOVE, stem | 64'hFFFF_0000_0000_0000, 4'd3);
    send_request(CMD_CONTAINS, stem, 4'd4);

    // Free a middle way, refill it and check the bucket is full again.
    fresh = place_in_bucket({$urandom, $urandom}, 8, bkt);
    send_request(CMD_REMOVE, fill[1], 4'(fill_len[1]));
    send_request(CMD_INSERT, fresh, 4'd8);
    send_request(CMD_INSERT, fill[4], 4'(fill_len[4]));
    send_request(CMD_CONTAINS, fill[1], 4'(fill_len[1]));

    send_request(CMD_CLEAR, {$urandom, $urandom}, 4'($urandom));
    send_request(CMD_CONTAINS, '1, 4'd8);
    send_request(CMD_REMOVE, 64'd0, 4'd1);
  endtask

  // Keys are drawn from a small set that crowds a few buckets, with some keys
  // being one-byte extensions of others in the same bucket.
  task automatic build_key_pool();
    int unsigned targets [POOL_BUCKETS];
    int unsigned tgt;
    int unsigned prev;
    foreach (targets[t]) targets[t] = $urandom_range(0, NBUCKETS - 1);
    for (int i = 0; i < POOL_SIZE; i++) begin
      tgt = targets[i % POOL_BUCKETS];
      prev = (i >= POOL_BUCKETS) ? i - POOL_BUCKETS : 0;
      if (i >= POOL_BUCKETS && pool_len[prev] < MAX_KEY_BYTES && $urandom_range(0, 2) == 0) begin
        pool_len[i] = pool_len[prev] + 1;
        pool_key[i] = place_in_bucket(pool_key[prev], pool_len[i], tgt);
      end else begin
        pool_len[i] = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, MAX_KEY_BYTES);
        pool_key[i] = place_in_bucket({$urandom, $urandom}, pool_len[i], tgt);
      end
    end
  endtask

  task automatic test_random_traffic(logic [63:0] seed_value);
    int unsigned roll;
    int unsigned idx;
    int unsigned n;
    logic [3:0] len_field;
    logic [63:0] garbage;
    logic [CMD_W-1:0] cmd;
    drain_stream();
    set_hash_seed(seed_value);
    build_key_pool();
    for (int it = 0; it < PHASE_ITEMS; it++) begin
      roll = $urandom_range(0, 99);
      idx = $urandom_range(0, POOL_SIZE - 1);
      garbage = {$urandom, $urandom};
      if (roll < 5) begin
        send_request(CMD_W'($urandom), garbage, 4'($urandom));
      end else if (roll < 7) begin
        send_request(CMD_CLEAR, garbage, 4'($urandom));
      end else begin
        cmd = (roll < 50) ? CMD_INSERT : (roll < 70) ? CMD_REMOVE : CMD_CONTAINS;
        n = pool_len[idx];
        len_field = (n == MAX_KEY_BYTES && $urandom_range(0, 3) == 0) ?
                    4'($urandom_range(9, 15)) : 4'(n);
        send_request(cmd, pool_key[idx] | (garbage & ~low_mask(n)), len_field);
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    foreach (shadow_valid[s]) shadow_valid[s] = 1'b0;
    rst_ni <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tuser_i <= CMD_INSERT;
    m_axis_tready_i <= 1'b0;
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    paddr_i <= '0;
    pwdata_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_directed_cases();
    test_random_traffic('0);
    test_random_traffic('1);
    test_random_traffic({$urandom, $urandom});
    test_random_traffic({$urandom, $urandom});
    test_random_traffic(HASH_SEED_RESET);
    drain_stream();

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ hash_set_engine.f @@
rtl/core/hse_pkg.sv
rtl/core/hse_hash.sv
rtl/core/hash_set_engine.sv
rtl/core/hse_checker.sv
tb/tb.sv
